// ===== design/ilha_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the implicit-list heap allocator.
// Used by ilha_ctrl, ilha_dp and the top level.
package ilha_pkg;

    localparam logic [31:0] PROLOGUE_PAYLOAD = 32'd8;
    localparam logic [31:0] SPLIT_MIN        = 32'd16;
    localparam logic [16:0] MIN_BLOCK        = 17'd16;
    localparam logic [1:0]  STATUS_OK        = 2'd0;
    localparam logic [1:0]  STATUS_ZERO      = 2'd1;
    localparam logic [1:0]  STATUS_NO_MEM    = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_IDLE, OP_DECODE, OP_RD_A4, OP_FR_SET,
        OP_PW_H, OP_RD_H, OP_PW_F, OP_RD_BP8, OP_MG_P, OP_MG_S2, OP_MG_PA,
        OP_MG_SZ, OP_MG_NA, OP_MG_C1, OP_MG_CA, OP_MG_CB, OP_RD_BP4,
        OP_MG_ROV, OP_RD_ROV, OP_S1, OP_S2_INIT, OP_S2, OP_CV, OP_CV_N2,
        OP_GR0, OP_GR1, OP_GR2, OP_GR3, OP_EMIT
    } op_t;

    typedef enum logic [5:0] {
        ST_INIT, ST_IDLE, ST_DECODE, ST_FR_RD, ST_FR_SET,
        ST_PW_H, ST_PW_R, ST_PW_F,
        ST_MG0, ST_MG1, ST_MG2, ST_MG3, ST_MG4, ST_MG5, ST_MG6,
        ST_MG_CA, ST_MG_CB, ST_MG_RV, ST_MG_RV2,
        ST_S1_RD, ST_S1_CK, ST_S2_INIT, ST_S2_RD, ST_S2_CK,
        ST_CV_RD, ST_CV_CK, ST_CV_N, ST_CV_N2,
        ST_GR0, ST_GR1, ST_GR2, ST_GR3, ST_EMIT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic acc;
        logic is_free;
        logic is_zero;
        logic fit;
        logic s1_exit;
        logic s2_go;
        logic pa;
        logic na;
        logic cv_small;
        logic gr_fail;
        logic out_busy;
    } stat_t;

endpackage

// ===== design/implicit_list_heap_allocator.sv =====
`timescale 1ns / 1ps
// Boundary-tag heap allocator with a roving search over one heap word memory.
// Zero size is answered at once; a free marks the block free and merges neighbours;
// an allocate walks blocks from the rover, wraps once, splits a large fit and grows
// the break when none fits; each block visit reads then checks on the one read port.
// One request at a time; the next beat is taken only after the result is issued.
// After reset a clearing pass writes the heap image, min(HEAP_WORDS, 16384) words.
module implicit_list_heap_allocator
    import ilha_pkg::*;
#(
    parameter int HEAP_WORDS  = 16384,
    parameter int CHUNK_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_size, block_addr
    input  logic [0:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // payload_addr
    output logic [1:0]  m_tuser    // status
);

    cmd_t  cmd;
    stat_t st;

    ilha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .cmd     (cmd)
    );

    ilha_dp #(
        .HEAP_WORDS  (HEAP_WORDS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== design/ilha_ctrl.sv =====
`timescale 1ns / 1ps
// Allocator controller: sequences memory reads and writes of each request.
// Depends on ilha_pkg; drives ilha_dp through cmd_t and reads stat_t.
module ilha_ctrl
    import ilha_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    state_t pair_ret_reg, pair_ret_next;
    state_t mg_ret_reg, mg_ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            pair_ret_reg <= ST_EMIT;
            mg_ret_reg   <= ST_EMIT;
        end else begin
            state_reg    <= state_next;
            pair_ret_reg <= pair_ret_next;
            mg_ret_reg   <= mg_ret_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        pair_ret_next = pair_ret_reg;
        mg_ret_next   = mg_ret_reg;
        unique case (state_reg)
            ST_INIT:    if (st.clr_done) state_next = ST_IDLE;
            ST_IDLE:    if (st.acc) state_next = ST_DECODE;
            ST_DECODE: begin
                if (st.is_free)      state_next = ST_FR_RD;
                else if (st.is_zero) state_next = ST_EMIT;
                else                 state_next = ST_S1_RD;
            end
            ST_FR_RD:   state_next = ST_FR_SET;
            ST_FR_SET: begin
                state_next    = ST_PW_H;
                pair_ret_next = ST_MG0;
                mg_ret_next   = ST_EMIT;
            end
            ST_PW_H:    state_next = ST_PW_R;
            ST_PW_R:    state_next = ST_PW_F;
            ST_PW_F:    state_next = pair_ret_reg;
            ST_MG0:     state_next = ST_MG1;
            ST_MG1:     state_next = ST_MG2;
            ST_MG2:     state_next = ST_MG3;
            ST_MG3:     state_next = ST_MG4;
            ST_MG4:     state_next = ST_MG5;
            ST_MG5:     state_next = ST_MG6;
            ST_MG6: begin
                if (st.pa && st.na) begin
                    state_next = ST_MG_RV;
                end else if (st.pa) begin
                    state_next    = ST_PW_H;
                    pair_ret_next = ST_MG_RV;
                end else begin
                    state_next = ST_MG_CA;
                end
            end
            ST_MG_CA:   state_next = ST_MG_CB;
            ST_MG_CB:   state_next = ST_MG_RV;
            ST_MG_RV:   state_next = ST_MG_RV2;
            ST_MG_RV2:  state_next = mg_ret_reg;
            ST_S1_RD:   state_next = ST_S1_CK;
            ST_S1_CK: begin
                if (st.s1_exit)  state_next = ST_S2_INIT;
                else if (st.fit) state_next = ST_CV_RD;
                else             state_next = ST_S1_RD;
            end
            ST_S2_INIT: state_next = ST_S2_RD;
            ST_S2_RD:   state_next = st.s2_go ? ST_S2_CK : ST_GR0;
            ST_S2_CK:   state_next = st.fit ? ST_CV_RD : ST_S2_RD;
            ST_CV_RD:   state_next = ST_CV_CK;
            ST_CV_CK: begin
                state_next    = ST_PW_H;
                pair_ret_next = st.cv_small ? ST_EMIT : ST_CV_N;
            end
            ST_CV_N:    state_next = ST_CV_N2;
            ST_CV_N2: begin
                state_next    = ST_PW_H;
                pair_ret_next = ST_EMIT;
            end
            ST_GR0:     state_next = st.gr_fail ? ST_EMIT : ST_GR1;
            ST_GR1:     state_next = ST_GR2;
            ST_GR2: begin
                state_next  = ST_MG0;
                mg_ret_next = ST_GR3;
            end
            ST_GR3:     state_next = ST_CV_RD;
            ST_EMIT:    if (!st.out_busy) state_next = ST_IDLE;
            default:    state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            ST_INIT:    cmd.op = OP_CLEAR;
            ST_IDLE:    cmd.op = OP_IDLE;
            ST_DECODE:  cmd.op = OP_DECODE;
            ST_FR_RD:   cmd.op = OP_RD_A4;
            ST_FR_SET:  cmd.op = OP_FR_SET;
            ST_PW_H:    cmd.op = OP_PW_H;
            ST_PW_R:    cmd.op = OP_RD_H;
            ST_PW_F:    cmd.op = OP_PW_F;
            ST_MG0:     cmd.op = OP_RD_BP8;
            ST_MG1:     cmd.op = OP_MG_P;
            ST_MG2:     cmd.op = OP_MG_S2;
            ST_MG3:     cmd.op = OP_MG_PA;
            ST_MG4:     cmd.op = OP_MG_SZ;
            ST_MG5:     cmd.op = OP_MG_NA;
            ST_MG6:     cmd.op = OP_MG_C1;
            ST_MG_CA:   cmd.op = OP_MG_CA;
            ST_MG_CB:   cmd.op = OP_MG_CB;
            ST_MG_RV:   cmd.op = OP_RD_BP4;
            ST_MG_RV2:  cmd.op = OP_MG_ROV;
            ST_S1_RD:   cmd.op = OP_RD_ROV;
            ST_S1_CK:   cmd.op = OP_S1;
            ST_S2_INIT: cmd.op = OP_S2_INIT;
            ST_S2_RD:   cmd.op = OP_RD_ROV;
            ST_S2_CK:   cmd.op = OP_S2;
            ST_CV_RD:   cmd.op = OP_RD_BP4;
            ST_CV_CK:   cmd.op = OP_CV;
            ST_CV_N:    cmd.op = OP_RD_BP4;
            ST_CV_N2:   cmd.op = OP_CV_N2;
            ST_GR0:     cmd.op = OP_GR0;
            ST_GR1:     cmd.op = OP_GR1;
            ST_GR2:     cmd.op = OP_GR2;
            ST_GR3:     cmd.op = OP_GR3;
            ST_EMIT:    cmd.op = st.out_busy ? OP_NONE : OP_EMIT;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== design/ilha_dp.sv =====
`timescale 1ns / 1ps
// Allocator datapath: heap word memory, block pointers, rover, break and beat ports.
// Depends on ilha_pkg; executes the cmd_t issued by ilha_ctrl.
module ilha_dp
    import ilha_pkg::*;
#(
    parameter int HEAP_WORDS  = 16384,
    parameter int CHUNK_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       st,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser
);

    localparam int AW     = $clog2(HEAP_WORDS);
    localparam int LIMIT  = (HEAP_WORDS * 4 > 65536) ? 65536 : HEAP_WORDS * 4;
    localparam int LW     = LIMIT / 4;
    localparam int CAP    = LIMIT / 8 + 2;
    localparam int CNTW   = $clog2(CAP + 1);
    localparam int CHW    = CHUNK_BYTES / 4;
    localparam int ISZ    = (CHW + CHW % 2) * 4;
    localparam bit IOK    = (ISZ <= LIMIT) && (16 <= LIMIT - ISZ);
    localparam int IBRK   = IOK ? 16 + ISZ : 16;
    localparam logic [31:0] LIMIT32 = 32'(LIMIT);

    logic [31:0] mem [HEAP_WORDS];
    logic [31:0] rq_reg;
    logic        roob_reg;
    logic [31:0] ra, wa, wd;
    logic        we;
    logic [AW-1:0] widx;

    logic [AW-1:0] clr_reg;
    logic [31:0] rov_reg, bp_reg, p_reg, n_reg, sz_reg, s2_reg, nsz_reg, h_reg, v_reg, old_reg;
    logic [16:0] brk_reg;
    logic [16:0] asz_reg;
    logic [CNTW-1:0] cnt_reg;
    logic        pa_reg, na_reg, cmd_reg;
    logic [15:0] req_reg, addr_reg, pay_reg;
    logic [1:0]  stat_reg;
    logic        mv_reg;
    logic [15:0] mdata_reg;
    logic [1:0]  muser_reg;

    logic [31:0] rdata, tag, init_val, clr32, gsz, mg_sum, diff;
    logic        al, acc;
    logic [17:0] ext;
    logic [15:0] w16;

    assign rdata = roob_reg ? 32'd1 : rq_reg;
    assign tag   = rdata & 32'hFFFF_FFF8;
    assign al    = rdata[0];
    assign acc   = s_tvalid && s_tready;
    assign clr32 = 32'(clr_reg);

    assign ext = (asz_reg > 17'(CHUNK_BYTES)) ? 18'(asz_reg) : 18'(CHUNK_BYTES);
    assign w16 = ext[17:2];
    assign gsz = {14'd0, (w16 + {15'd0, w16[0]}), 2'b00};
    assign mg_sum = sz_reg + s2_reg + (na_reg ? 32'd0 : nsz_reg);
    assign diff = tag - 32'(asz_reg);

    always_comb begin
        init_val = 32'd0;
        if (clr32 == 32'd1 || clr32 == 32'd2) init_val = 32'd9;
        else if (clr32 == 32'd3) init_val = IOK ? 32'(ISZ) : 32'd1;
        else if (IOK && clr32 == 32'((8 + ISZ) / 4)) init_val = 32'(ISZ);
        else if (IOK && clr32 == 32'((12 + ISZ) / 4)) init_val = 32'd1;
    end

    always_comb begin
        case (cmd.op)
            OP_RD_A4:  ra = {16'd0, addr_reg} - 32'd4;
            OP_RD_H:   ra = h_reg;
            OP_RD_BP8: ra = bp_reg - 32'd8;
            OP_MG_P:   ra = bp_reg - tag - 32'd4;
            OP_MG_S2:  ra = p_reg + tag - 32'd8;
            OP_MG_PA:  ra = bp_reg - 32'd4;
            OP_MG_SZ:  ra = bp_reg + tag - 32'd4;
            OP_RD_BP4: ra = bp_reg - 32'd4;
            OP_RD_ROV: ra = rov_reg - 32'd4;
            default:   ra = 32'd0;
        endcase
    end

    always_comb begin
        wa = 32'd0;
        wd = 32'd0;
        case (cmd.op)
            OP_PW_H: begin
                wa = h_reg;
                wd = v_reg;
            end
            OP_PW_F: begin
                wa = h_reg + tag - 32'd4;
                wd = v_reg;
            end
            OP_MG_CA: begin
                wa = na_reg ? n_reg - 32'd8 : n_reg + nsz_reg - 32'd8;
                wd = mg_sum;
            end
            OP_MG_CB: begin
                wa = p_reg - 32'd4;
                wd = v_reg;
            end
            OP_GR0: begin
                wa = 32'(brk_reg) - 32'd4;
                wd = gsz;
            end
            OP_GR1: begin
                wa = 32'(brk_reg) + gsz - 32'd8;
                wd = gsz;
            end
            OP_GR2: begin
                wa = 32'(brk_reg) + gsz - 32'd4;
                wd = 32'd1;
            end
            default: begin
                wa = 32'd0;
                wd = 32'd0;
            end
        endcase
    end

    always_comb begin
        we   = 1'b0;
        widx = wa[AW+1:2];
        case (cmd.op)
            OP_CLEAR: begin
                we   = 1'b1;
                widx = clr_reg;
            end
            OP_PW_H, OP_PW_F, OP_MG_CA, OP_MG_CB, OP_GR1, OP_GR2: we = wa < LIMIT32;
            OP_GR0: we = (wa < LIMIT32) && !st.gr_fail;
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) mem[widx] <= (cmd.op == OP_CLEAR) ? init_val : wd;
        rq_reg   <= mem[ra[AW+1:2]];
        roob_reg <= ra >= LIMIT32;
    end

    always_comb begin
        st.clr_done = clr32 == 32'(LW - 1);
        st.acc      = acc;
        st.is_free  = cmd_reg;
        st.is_zero  = req_reg == 16'd0;
        st.fit      = !al && tag >= 32'(asz_reg);
        st.s1_exit  = !(tag != 32'd0 && cnt_reg < CNTW'(CAP));
        st.s2_go    = rov_reg < old_reg && cnt_reg < CNTW'(CAP);
        st.pa       = pa_reg;
        st.na       = na_reg;
        st.cv_small = diff <= SPLIT_MIN;
        st.gr_fail  = gsz > LIMIT32 || 32'(brk_reg) > LIMIT32 - gsz;
        st.out_busy = mv_reg && !m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            rov_reg <= PROLOGUE_PAYLOAD;
            brk_reg <= 17'(IBRK);
            mv_reg  <= 1'b0;
        end else begin
            if (cmd.op == OP_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cmd.op == OP_EMIT) mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
            case (cmd.op)
                OP_MG_ROV:
                    if (rov_reg > bp_reg && rov_reg < bp_reg + tag) rov_reg <= bp_reg;
                OP_S1:
                    if (!st.s1_exit && !st.fit) rov_reg <= rov_reg + tag;
                OP_S2_INIT: rov_reg <= PROLOGUE_PAYLOAD;
                OP_S2:
                    if (!st.fit) rov_reg <= rov_reg + tag;
                OP_GR2: brk_reg <= brk_reg + gsz[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_IDLE:
                if (acc) begin
                    cmd_reg  <= s_tuser[0];
                    req_reg  <= s_tdata[15:0];
                    addr_reg <= s_tdata[31:16];
                end
            OP_DECODE: begin
                pay_reg  <= 16'd0;
                stat_reg <= (!cmd_reg && req_reg == 16'd0) ? STATUS_ZERO : STATUS_OK;
                asz_reg  <= (req_reg <= 16'd8) ? MIN_BLOCK
                          : ((17'(req_reg) + 17'd15) & ~17'd7);
                old_reg  <= rov_reg;
                cnt_reg  <= '0;
            end
            OP_FR_SET: begin
                h_reg  <= {16'd0, addr_reg} - 32'd4;
                v_reg  <= tag;
                bp_reg <= {16'd0, addr_reg};
            end
            OP_MG_P:  p_reg <= bp_reg - tag;
            OP_MG_S2: s2_reg <= tag;
            OP_MG_PA: pa_reg <= al;
            OP_MG_SZ: begin
                sz_reg <= tag;
                n_reg  <= bp_reg + tag;
            end
            OP_MG_NA: begin
                na_reg  <= al;
                nsz_reg <= tag;
            end
            OP_MG_C1: begin
                h_reg <= bp_reg - 32'd4;
                v_reg <= sz_reg + nsz_reg;
            end
            OP_MG_CA: v_reg <= mg_sum;
            OP_MG_CB: bp_reg <= p_reg;
            OP_S1:
                if (!st.s1_exit) begin
                    if (st.fit) begin
                        bp_reg  <= rov_reg;
                        pay_reg <= rov_reg[15:0];
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
            OP_S2_INIT: cnt_reg <= '0;
            OP_S2:
                if (st.fit) begin
                    bp_reg  <= rov_reg;
                    pay_reg <= rov_reg[15:0];
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            OP_CV: begin
                nsz_reg <= diff;
                h_reg   <= bp_reg - 32'd4;
                v_reg   <= st.cv_small ? (tag | 32'd1) : (32'(asz_reg) | 32'd1);
            end
            OP_CV_N2: begin
                h_reg <= bp_reg + tag - 32'd4;
                v_reg <= nsz_reg;
            end
            OP_GR0:
                if (st.gr_fail) stat_reg <= STATUS_NO_MEM;
            OP_GR2: bp_reg <= 32'(brk_reg);
            OP_GR3: pay_reg <= bp_reg[15:0];
            OP_EMIT: begin
                mdata_reg <= pay_reg;
                muser_reg <= stat_reg;
            end
            default: ;
        endcase
    end

    assign s_tready = cmd.op == OP_IDLE;
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule
